// File: rtl/oiap_pkg.sv
// Shared types and constants of the outside-in autocorrelation prune engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package oiap_pkg;

  localparam int SEQ_LENGTH_DEFAULT = 70;

  localparam int BOUND_W  = 7;
  localparam int SUM_W    = 8;
  localparam int CNT_W    = 7;
  localparam int LAG_W    = 7;
  localparam int PAIR_W   = 6;
  localparam int ERR_W    = 2;
  localparam int TDELTA_W = 3;

  localparam logic [BOUND_W-1:0] CORR_BOUND_RESET = 7'd4;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic func;
    logic left_value;
    logic right_value;
  } in_word_t;

  typedef struct packed {
    logic              feasible;
    logic [PAIR_W-1:0] pair_count;
    logic              complete;
    logic [ERR_W-1:0]  error;
  } out_word_t;

  // One slot of the lag cell row: either an update for one lag or the
  // check token that collects the per-lag verdicts.
  typedef struct packed {
    logic                valid;
    logic                chk;
    logic                ok;
    logic [LAG_W-1:0]    lag;
    logic [TDELTA_W-1:0] delta;
    logic [TDELTA_W-1:0] cnt_delta;
  } token_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PREP,
    ST_WALK_A,
    ST_WALK_B,
    ST_PAIR,
    ST_CHECK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/outside_in_autocorrelation_prune_engine_top.sv
// Top level of the outside-in autocorrelation prune engine: bound register,
// sequencer and the row of lag cells. Depends on oiap_pkg, oiap_ctrl, oiap_cell.
`default_nettype none

//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid / in_ready    | in_data: func, left/right
//  out     | output    | out_valid / out_ready  | out_data: feasible, count..
//  cfg     | input     | cfg_we                 | cfg_data: corr_bound
//
// One item at a time: a new word is taken only in the idle state. A push walks
// two tokens per earlier pair, then the pair token and the check token; a pop
// first fetches the top pair; a rejected step issues only the check token. The
// single token lane and the walk of the check token down the SEQ_LENGTH-1 lag
// cells set the time per item. Reset clears all lag sums and counts at once. A
// result word waits in the output register while the next item is taken.

module outside_in_autocorrelation_prune_engine_top #(
  parameter int SEQ_LENGTH = oiap_pkg::SEQ_LENGTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire oiap_pkg::in_word_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output oiap_pkg::out_word_t               out_data,
  input  wire logic                         cfg_we,
  input  wire logic [oiap_pkg::BOUND_W-1:0] cfg_data
);

  logic [oiap_pkg::BOUND_W-1:0] corr_bound;
  oiap_pkg::token_t             chain [SEQ_LENGTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      corr_bound <= oiap_pkg::CORR_BOUND_RESET;
    end else if (cfg_we) begin
      corr_bound <= cfg_data;
    end
  end

  oiap_ctrl #(
    .SEQ_LENGTH(SEQ_LENGTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .tail     (chain[SEQ_LENGTH-1]),
    .tok      (chain[0])
  );

  // Cell k keeps lag k; tokens move one cell per cycle.
  for (genvar k = 1; k < SEQ_LENGTH; k++) begin : g_cell
    oiap_cell #(
      .SEQ_LENGTH(SEQ_LENGTH),
      .LAG       (k)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .bound  (corr_bound),
      .tok_in (chain[k-1]),
      .tok_out(chain[k])
    );
  end

endmodule

`default_nettype wire

// File: rtl/oiap_cell.sv
// One lag cell: holds the correlation sum and term count of a single lag and
// passes the token slot on to the next cell. Depends on oiap_pkg.
`default_nettype none

module oiap_cell #(
  parameter int SEQ_LENGTH = oiap_pkg::SEQ_LENGTH_DEFAULT,
  parameter int LAG        = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [oiap_pkg::BOUND_W-1:0] bound,
  input  wire oiap_pkg::token_t             tok_in,
  output oiap_pkg::token_t                  tok_out
);

  localparam int SW = oiap_pkg::SUM_W;
  localparam int CW = oiap_pkg::CNT_W;
  localparam int TW = oiap_pkg::TDELTA_W;

  logic signed [SW-1:0] sum;
  logic [CW-1:0]        cnt;
  logic                 hit;
  logic [SW-1:0]        mag;
  logic [SW:0]          limit;
  logic                 pass;
  oiap_pkg::token_t     tok_pass;

  assign hit = tok_in.valid && !tok_in.chk
               && (tok_in.lag == oiap_pkg::LAG_W'(LAG));

  always_comb begin
    mag   = sum[SW-1] ? (~sum + 1'b1) : sum;
    // Bound plus the terms of this lag that are not fixed yet.
    limit = (SW+1)'(bound) + (SW+1)'(SEQ_LENGTH - LAG) - (SW+1)'(cnt);
    pass  = ({1'b0, mag} <= limit);
    tok_pass    = tok_in;
    tok_pass.ok = tok_in.ok && (!tok_in.chk || pass);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      cnt     <= '0;
      tok_out <= '0;
    end else begin
      if (hit) begin
        sum <= sum + {{(SW-TW){tok_in.delta[TW-1]}}, tok_in.delta};
        cnt <= cnt + {{(CW-TW){tok_in.cnt_delta[TW-1]}}, tok_in.cnt_delta};
      end
      tok_out <= tok_pass;
    end
  end

endmodule

`default_nettype wire

// File: rtl/oiap_ctrl.sv
// Step sequencer: input handshake, pair depth, end-value memory, token issue
// into the lag cell row and the output register. Depends on oiap_pkg.
`default_nettype none

module oiap_ctrl #(
  parameter int SEQ_LENGTH = oiap_pkg::SEQ_LENGTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire oiap_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output oiap_pkg::out_word_t      out_data,
  input  wire oiap_pkg::token_t    tail,
  output oiap_pkg::token_t         tok
);

  localparam int HALF = SEQ_LENGTH / 2;
  localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int DW   = $clog2(HALF + 1);
  localparam bit EVEN = (SEQ_LENGTH % 2) == 0;
  localparam int LW   = oiap_pkg::LAG_W;
  localparam int TW   = oiap_pkg::TDELTA_W;

  localparam logic [TW-1:0] D_PLUS2  = 3'b010;
  localparam logic [TW-1:0] D_MINUS2 = 3'b110;
  localparam logic [TW-1:0] D_PLUS1  = 3'b001;
  localparam logic [TW-1:0] D_MINUS1 = 3'b111;
  localparam logic [TW-1:0] D_ZERO   = 3'b000;

  oiap_pkg::state_t state, state_next;

  logic [1:0]    pair_mem [HALF];
  logic [1:0]    mem_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] cur_j;
  logic [DW-1:0] depth;
  logic [DW-1:0] work_d;
  logic          vl;
  logic          vr;
  logic          is_pop;
  logic [oiap_pkg::ERR_W-1:0] err;
  logic          feas;

  logic             accept;
  logic             push_ok;
  logic             pop_ok;
  logic             out_free;
  logic             last_j;
  oiap_pkg::token_t tok_next;

  // Sum of two element products, negated when the pair is being removed.
  function automatic logic [TW-1:0] two_delta(input logic a, input logic b,
                                              input logic neg);
    logic [TW-1:0] val;
    if (a == b) begin
      val = (a ^ neg) ? D_PLUS2 : D_MINUS2;
    end else begin
      val = D_ZERO;
    end
    return val;
  endfunction

  always_comb begin
    accept   = in_valid && in_ready;
    push_ok  = accept && (in_data.func == oiap_pkg::FUNC_PUSH)
               && (depth != DW'(HALF));
    pop_ok   = accept && (in_data.func == oiap_pkg::FUNC_POP) && (depth != '0);
    out_free = !out_valid || out_ready;
    last_j   = ((DW'(cur_j) + 1'b1) == work_d);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      oiap_pkg::ST_IDLE: begin
        if (accept) begin
          if (push_ok) begin
            state_next = oiap_pkg::ST_PREP;
          end else if (pop_ok) begin
            state_next = oiap_pkg::ST_FETCH;
          end else begin
            state_next = oiap_pkg::ST_CHECK;
          end
        end
      end
      oiap_pkg::ST_FETCH:  state_next = oiap_pkg::ST_PREP;
      oiap_pkg::ST_PREP: begin
        state_next = (work_d != '0) ? oiap_pkg::ST_WALK_A : oiap_pkg::ST_PAIR;
      end
      oiap_pkg::ST_WALK_A: state_next = oiap_pkg::ST_WALK_B;
      oiap_pkg::ST_WALK_B: begin
        state_next = last_j ? oiap_pkg::ST_PAIR : oiap_pkg::ST_WALK_A;
      end
      oiap_pkg::ST_PAIR:   state_next = oiap_pkg::ST_CHECK;
      oiap_pkg::ST_CHECK:  state_next = oiap_pkg::ST_DRAIN;
      oiap_pkg::ST_DRAIN: begin
        if (tail.valid && tail.chk) begin
          state_next = oiap_pkg::ST_RESULT;
        end
      end
      oiap_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = oiap_pkg::ST_IDLE;
        end
      end
      default: state_next = oiap_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and the token issued into the first lag cell.
  // Per earlier pair j, one token covers lag d-j and one covers lag N-1-d-j;
  // each gathers the two products that land on that lag.
  always_comb begin
    in_ready = 1'b0;
    tok_next = '0;
    unique case (state)
      oiap_pkg::ST_IDLE: in_ready = !rst;
      oiap_pkg::ST_WALK_A: begin
        tok_next.valid     = 1'b1;
        tok_next.lag       = LW'(work_d) - LW'(cur_j);
        tok_next.delta     = two_delta(vl == mem_q[1], vr == mem_q[0], is_pop);
        tok_next.cnt_delta = is_pop ? D_MINUS2 : D_PLUS2;
      end
      oiap_pkg::ST_WALK_B: begin
        tok_next.valid     = 1'b1;
        tok_next.lag       = LW'(SEQ_LENGTH - 1) - LW'(work_d) - LW'(cur_j);
        tok_next.delta     = two_delta(vl == mem_q[0], vr == mem_q[1], is_pop);
        tok_next.cnt_delta = is_pop ? D_MINUS2 : D_PLUS2;
      end
      oiap_pkg::ST_PAIR: begin
        tok_next.valid     = 1'b1;
        tok_next.lag       = LW'(SEQ_LENGTH - 1) - (LW'(work_d) << 1);
        tok_next.delta     = ((vl == vr) ^ is_pop) ? D_PLUS1 : D_MINUS1;
        tok_next.cnt_delta = is_pop ? D_MINUS1 : D_PLUS1;
      end
      oiap_pkg::ST_CHECK: begin
        tok_next.valid = 1'b1;
        tok_next.chk   = 1'b1;
        tok_next.ok    = 1'b1;
      end
      oiap_pkg::ST_FETCH, oiap_pkg::ST_PREP, oiap_pkg::ST_DRAIN,
      oiap_pkg::ST_RESULT: begin
        tok_next = '0;
      end
      default: tok_next = '0;
    endcase
  end

  // End-value memory: entry j holds the left and right element of pair j.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      pair_mem[AW'(depth)] <= {in_data.left_value, in_data.right_value};
    end
    mem_q <= pair_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oiap_pkg::ST_IDLE;
      depth <= '0;
      tok   <= '0;
    end else begin
      state <= state_next;
      tok   <= tok_next;
      if (push_ok) begin
        depth <= depth + 1'b1;
      end else if (pop_ok) begin
        depth <= depth - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_pop  <= pop_ok;
      rd_addr <= pop_ok ? AW'(depth - 1'b1) : '0;
      if (push_ok) begin
        err    <= oiap_pkg::ERR_NONE;
        work_d <= depth;
        vl     <= in_data.left_value;
        vr     <= in_data.right_value;
      end else if (pop_ok) begin
        err     <= oiap_pkg::ERR_NONE;
        work_d  <= depth - 1'b1;
      end else if (in_data.func == oiap_pkg::FUNC_PUSH) begin
        err <= oiap_pkg::ERR_FULL;
      end else begin
        err <= oiap_pkg::ERR_EMPTY;
      end
    end
    case (state)
      oiap_pkg::ST_FETCH: rd_addr <= '0;
      oiap_pkg::ST_PREP: begin
        cur_j <= '0;
        if (is_pop) begin
          vl <= mem_q[1];
          vr <= mem_q[0];
        end
      end
      oiap_pkg::ST_WALK_A: rd_addr <= AW'(cur_j + 1'b1);
      oiap_pkg::ST_WALK_B: cur_j <= AW'(cur_j + 1'b1);
      oiap_pkg::ST_DRAIN: begin
        if (tail.valid && tail.chk) begin
          feas <= tail.ok;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished word waits here while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == oiap_pkg::ST_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == oiap_pkg::ST_RESULT) && out_free) begin
      out_data.feasible   <= feas;
      out_data.pair_count <= oiap_pkg::PAIR_W'(depth);
      out_data.complete   <= EVEN && (depth == DW'(HALF));
      out_data.error      <= err;
    end
  end

endmodule

`default_nettype wire
